### rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg
// Types and codes shared by the CPF item list parser and its test bench.
// ----------------------------------------------------------------------------
package cpf_pkg;

    typedef enum logic [7:0] {
        PH_COUNT = 8'b0000_0001,
        PH_TYPE  = 8'b0000_0010,
        PH_LEN   = 8'b0000_0100,
        PH_CONN  = 8'b0000_1000,
        PH_SEQ   = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_SOCK  = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_DATA = 2'd2,
        KIND_SOCK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNC     = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_BAD_SOCK  = 2'd3
    } t_status;

    localparam logic [15:0] TYPE_ADDR_NULL = 16'h0000;
    localparam logic [15:0] TYPE_ADDR_CONN = 16'h00A1;
    localparam logic [15:0] TYPE_ADDR_SEQ  = 16'h8002;
    localparam logic [15:0] TYPE_DATA_CONN = 16'h00B1;
    localparam logic [15:0] TYPE_DATA_UCON = 16'h00B2;
    localparam logic [15:0] TYPE_SOCK_OT   = 16'h8000;
    localparam logic [15:0] TYPE_SOCK_TO   = 16'h8001;

    localparam logic [15:0] ADDR_CONN_LEN = 16'd4;
    localparam logic [15:0] ADDR_SEQ_LEN  = 16'd8;
    localparam logic [15:0] SOCK_LEN      = 16'd16;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] type_code;
        logic [31:0] conn_id;
        logic [31:0] seq_num;
        logic [7:0]  data_byte;
        logic        data_end;
        logic [15:0] sock_family;
        logic [15:0] sock_port;
        logic [31:0] sock_ipv4;
        logic        packet_end;
        t_status     status;
        logic [15:0] byte_offset;
    } t_result;

endpackage

### rtl/cpf_byte_if.sv
// ----------------------------------------------------------------------------
// cpf_byte_if
// Byte channel into the parser: one buffer byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface cpf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

### rtl/cpf_res_if.sv
// ----------------------------------------------------------------------------
// cpf_res_if
// Result channel out of the parser: one parsed item or end-of-packet report.
// ----------------------------------------------------------------------------
interface cpf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] type_code;
    logic [31:0] conn_id;
    logic [31:0] seq_num;
    logic [7:0]  data_byte;
    logic        data_end;
    logic [15:0] sock_family;
    logic [15:0] sock_port;
    logic [31:0] sock_ipv4;
    logic        packet_end;
    logic [1:0]  status;
    logic [15:0] byte_offset;

    modport source (
        output valid, output kind, output type_code, output conn_id, output seq_num,
        output data_byte, output data_end, output sock_family, output sock_port,
        output sock_ipv4, output packet_end, output status, output byte_offset,
        input ready
    );
    modport sink (
        input valid, input kind, input type_code, input conn_id, input seq_num,
        input data_byte, input data_end, input sock_family, input sock_port,
        input sock_ipv4, input packet_end, input status, input byte_offset,
        output ready
    );
endinterface

### rtl/cpf_item_list_parser_unit.sv
// ----------------------------------------------------------------------------
// cpf_item_list_parser_unit
// Byte-serial parser for a little-endian CPF item list: count, type, length,
// address / data / socket-address items, with error and truncation reports.
// ----------------------------------------------------------------------------
//  port    | dir | payload                                  | accepted when
//  i_in    | in  | byte_in, last_byte                       | valid && ready
//  o_out   | out | kind .. byte_offset (one result item)    | valid && ready
//
//  One byte per cycle while i_in.ready is high; the parse state updates in the cycle the byte is taken.
//  A result is loaded into o_out's register when the byte that causes it is taken.
//  i_in.ready is high while the result register is empty or being drained,
//  so a stalled o_out stops input only once a result is waiting.
//  Synchronous active-low reset returns the parser to waiting for an item count.
// ----------------------------------------------------------------------------
module cpf_item_list_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpf_byte_if.sink   i_in,
    cpf_res_if.source  o_out
);
    import cpf_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_idx,    n_idx;
    logic [15:0] r_items,  n_items;
    logic [15:0] r_type,   n_type;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_bytes,  n_bytes;
    logic [31:0] r_word,   n_word;
    logic [31:0] r_conn,   n_conn;
    logic [15:0] r_family, n_family;
    logic [15:0] r_port,   n_port;
    logic [15:0] r_offset, n_offset;
    t_result     r_res,    res;
    logic        r_out_valid;

    logic        acc;
    logic        emit;
    logic        item_done;
    logic        end_req;
    t_status     end_st;
    logic [7:0]  b;
    logic [15:0] v;
    logic [15:0] off_inc;
    logic [15:0] items_dec;
    logic [15:0] bytes_dec;
    logic [31:0] wacc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.byte_in;
    assign v          = r_word[15:0] | {b, 8'h00};
    assign off_inc    = (r_offset != 16'hFFFF) ? r_offset + 16'd1 : r_offset;
    assign items_dec  = r_items - 16'd1;
    assign bytes_dec  = r_bytes - 16'd1;
    assign wacc       = r_word | ({24'h0, b} << {r_idx[1:0], 3'b000});

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_items   = r_items;
        n_type    = r_type;
        n_len     = r_len;
        n_bytes   = r_bytes;
        n_word    = r_word;
        n_conn    = r_conn;
        n_family  = r_family;
        n_port    = r_port;
        n_offset  = r_offset;
        res       = '0;
        emit      = 1'b0;
        item_done = 1'b0;
        end_req   = 1'b0;
        end_st    = ST_OK;

        if (acc && r_phase != PH_DONE) begin
            n_offset = off_inc;
            unique case (r_phase) inside
                PH_COUNT, PH_TYPE, PH_LEN: begin
                    if (r_idx == 4'd0) begin
                        n_word = {24'h0, b};
                        n_idx  = 4'd1;
                    end else begin
                        n_idx = 4'd0;
                        if (r_phase == PH_COUNT) begin
                            n_items = v;
                            if (v == 16'd0) begin
                                end_req = 1'b1;
                            end else begin
                                n_phase = PH_TYPE;
                            end
                        end else if (r_phase == PH_TYPE) begin
                            n_type  = v;
                            n_phase = PH_LEN;
                        end else begin
                            n_len  = v;
                            n_word = '0;
                            unique case (r_type) inside
                                TYPE_ADDR_NULL, TYPE_ADDR_CONN, TYPE_ADDR_SEQ: begin
                                    if (v >= ADDR_CONN_LEN) begin
                                        n_phase = PH_CONN;
                                    end else begin
                                        emit          = 1'b1;
                                        res.kind      = KIND_ADDR;
                                        res.type_code = r_type;
                                        item_done     = 1'b1;
                                    end
                                end
                                TYPE_DATA_CONN, TYPE_DATA_UCON: begin
                                    if (v == 16'd0) begin
                                        item_done = 1'b1;
                                    end else begin
                                        n_bytes = v;
                                        n_phase = PH_DATA;
                                    end
                                end
                                TYPE_SOCK_OT, TYPE_SOCK_TO: begin
                                    if (v == SOCK_LEN) begin
                                        n_phase = PH_SOCK;
                                    end else begin
                                        res.type_code = r_type;
                                        end_req       = 1'b1;
                                        end_st        = ST_BAD_SOCK;
                                    end
                                end
                                default: begin
                                    res.type_code = r_type;
                                    end_req       = 1'b1;
                                    end_st        = ST_BAD_TYPE;
                                end
                            endcase
                        end
                    end
                end
                PH_CONN, PH_SEQ: begin
                    n_word = wacc;
                    n_idx  = r_idx + 4'd1;
                    if (r_idx >= 4'd3) begin
                        n_idx = 4'd0;
                        if (r_phase == PH_CONN) begin
                            n_conn = wacc;
                            n_word = '0;
                            if (r_len == ADDR_SEQ_LEN) begin
                                n_phase = PH_SEQ;
                            end else begin
                                emit          = 1'b1;
                                res.kind      = KIND_ADDR;
                                res.type_code = r_type;
                                res.conn_id   = wacc;
                                item_done     = 1'b1;
                            end
                        end else begin
                            emit          = 1'b1;
                            res.kind      = KIND_ADDR;
                            res.type_code = r_type;
                            res.conn_id   = r_conn;
                            res.seq_num   = wacc;
                            item_done     = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    emit          = 1'b1;
                    res.kind      = KIND_DATA;
                    res.type_code = r_type;
                    res.data_byte = b;
                    n_bytes       = bytes_dec;
                    if (bytes_dec == 16'd0) begin
                        res.data_end = 1'b1;
                        item_done    = 1'b1;
                    end
                end
                PH_SOCK: begin
                    if (r_idx < 4'd2) begin
                        n_family = {r_family[7:0], b};
                    end else if (r_idx < 4'd4) begin
                        n_port = {r_port[7:0], b};
                    end else if (r_idx < 4'd8) begin
                        n_word = {r_word[23:0], b};
                    end
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        emit            = 1'b1;
                        res.kind        = KIND_SOCK;
                        res.type_code   = r_type;
                        res.sock_family = r_family;
                        res.sock_port   = r_port;
                        res.sock_ipv4   = r_word;
                        n_family        = '0;
                        n_port          = '0;
                        n_word          = '0;
                        item_done       = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (item_done) begin
                n_items = items_dec;
                n_idx   = 4'd0;
                if (items_dec == 16'd0) begin
                    end_req = 1'b1;
                end else begin
                    n_phase = PH_TYPE;
                end
            end

            if (!end_req && i_in.last_byte) begin
                end_req = 1'b1;
                end_st  = ST_TRUNC;
            end

            if (end_req) begin
                emit            = 1'b1;
                res.packet_end  = 1'b1;
                res.status      = end_st;
                res.byte_offset = off_inc;
                n_phase         = PH_DONE;
            end
        end

        if (acc && i_in.last_byte) begin
            n_phase  = PH_COUNT;
            n_idx    = 4'd0;
            n_offset = '0;
            n_word   = '0;
            n_family = '0;
            n_port   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COUNT;
            r_idx       <= '0;
            r_items     <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_bytes     <= '0;
            r_word      <= '0;
            r_conn      <= '0;
            r_family    <= '0;
            r_port      <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_items  <= n_items;
            r_type   <= n_type;
            r_len    <= n_len;
            r_bytes  <= n_bytes;
            r_word   <= n_word;
            r_conn   <= n_conn;
            r_family <= n_family;
            r_port   <= n_port;
            r_offset <= n_offset;
            if (acc && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_res.kind;
    assign o_out.type_code   = r_res.type_code;
    assign o_out.conn_id     = r_res.conn_id;
    assign o_out.seq_num     = r_res.seq_num;
    assign o_out.data_byte   = r_res.data_byte;
    assign o_out.data_end    = r_res.data_end;
    assign o_out.sock_family = r_res.sock_family;
    assign o_out.sock_port   = r_res.sock_port;
    assign o_out.sock_ipv4   = r_res.sock_ipv4;
    assign o_out.packet_end  = r_res.packet_end;
    assign o_out.status      = r_res.status;
    assign o_out.byte_offset = r_res.byte_offset;

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.last_byte |=> r_phase == PH_COUNT && r_offset == 16'd0 && r_idx == 4'd0)
        else $error("last byte did not rearm the parser");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending result dropped");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");

    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.packet_end |-> r_res.status == ST_OK
            && r_res.byte_offset == 16'd0)
        else $error("status or offset set without packet end");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_phase == PH_DONE |=> r_phase == PH_DONE || r_phase == PH_COUNT)
        else $error("parser left done state without a last byte");

endmodule

### verif/cpf_item_list_parser_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpf_item_list_parser_unit_test
// Self-checking bench for the CPF item list parser. Byte buffers are fed in
// bursts; each accepted byte runs a bit-accurate parser model that queues the
// expected result, and every result from the block is checked in order.
// ----------------------------------------------------------------------------
module cpf_item_list_parser_unit_test;
    import cpf_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_BYTES = 1800;
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic i_clk;
    logic i_rst_n;

    cpf_byte_if in_if ();
    cpf_res_if  out_if ();

    cpf_item_list_parser_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_byte_item byte_queue[$];
    logic [7:0] frame_q[$];
    t_result    predicted_results[$];

    int total_bytes;
    int bytes_taken;
    int err_count;

    // parser model state
    t_phase      ph;
    logic [3:0]  fidx;
    logic [15:0] items_left;
    logic [15:0] itype;
    logic [15:0] ilen;
    logic [15:0] bytes_left;
    logic [31:0] acc;
    logic [31:0] conn_hold;
    logic [15:0] fam_hold;
    logic [15:0] port_hold;
    logic [15:0] offs;
    t_result     pr;
    bit          pemit;

    t_byte_item next_byte;
    int         gap_left;
    int         burst_left;

    t_result got;
    t_result want;
    int      rx_mode;
    int      rx_left;
    bit      rdy;

    logic hold_off;
    int   hold_left;
    int   hold_cyc;
    int   run_cycles;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    task automatic close_packet(input t_status st);
        pemit          = 1'b1;
        pr.packet_end  = 1'b1;
        pr.status      = st;
        pr.byte_offset = offs;
        ph             = PH_DONE;
    endtask

    task automatic finish_item();
        items_left = items_left - 16'd1;
        fidx       = '0;
        if (items_left == 16'd0) begin
            close_packet(ST_OK);
        end else begin
            ph = PH_TYPE;
        end
    endtask

    task automatic report_addr(input logic [31:0] cid, input logic [31:0] seq);
        pemit        = 1'b1;
        pr.kind      = KIND_ADDR;
        pr.type_code = itype;
        pr.conn_id   = cid;
        pr.seq_num   = seq;
        finish_item();
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [3:0]  idx;
        logic [15:0] v;
        idx   = fidx;
        pr    = '0;
        pemit = 1'b0;
        if (ph != PH_DONE) begin
            if (offs != 16'hFFFF) begin
                offs = offs + 16'd1;
            end
            case (ph) inside
                PH_COUNT, PH_TYPE, PH_LEN: begin
                    if (idx == 4'd0) begin
                        acc  = {24'd0, b};
                        fidx = 4'd1;
                    end else begin
                        v    = acc[15:0] | {b, 8'h00};
                        fidx = 4'd0;
                        if (ph == PH_COUNT) begin
                            items_left = v;
                            if (v == 16'd0) begin
                                close_packet(ST_OK);
                            end else begin
                                ph = PH_TYPE;
                            end
                        end else if (ph == PH_TYPE) begin
                            itype = v;
                            ph    = PH_LEN;
                        end else begin
                            ilen = v;
                            fidx = 4'd0;
                            acc  = '0;
                            case (itype) inside
                                TYPE_ADDR_NULL, TYPE_ADDR_CONN, TYPE_ADDR_SEQ: begin
                                    if (ilen >= ADDR_CONN_LEN) begin
                                        ph = PH_CONN;
                                    end else begin
                                        report_addr('0, '0);
                                    end
                                end
                                TYPE_DATA_CONN, TYPE_DATA_UCON: begin
                                    if (ilen == 16'd0) begin
                                        finish_item();
                                    end else begin
                                        bytes_left = ilen;
                                        ph         = PH_DATA;
                                    end
                                end
                                TYPE_SOCK_OT, TYPE_SOCK_TO: begin
                                    if (ilen == SOCK_LEN) begin
                                        ph = PH_SOCK;
                                    end else begin
                                        pr.type_code = itype;
                                        close_packet(ST_BAD_SOCK);
                                    end
                                end
                                default: begin
                                    pr.type_code = itype;
                                    close_packet(ST_BAD_TYPE);
                                end
                            endcase
                        end
                    end
                end
                PH_CONN, PH_SEQ: begin
                    acc  = acc | ({24'd0, b} << {idx[1:0], 3'b000});
                    fidx = idx + 4'd1;
                    if (idx >= 4'd3) begin
                        fidx = 4'd0;
                        if (ph == PH_CONN) begin
                            conn_hold = acc;
                            acc       = '0;
                            if (ilen == ADDR_SEQ_LEN) begin
                                ph = PH_SEQ;
                            end else begin
                                report_addr(conn_hold, '0);
                            end
                        end else begin
                            report_addr(conn_hold, acc);
                        end
                    end
                end
                PH_DATA: begin
                    pemit        = 1'b1;
                    pr.kind      = KIND_DATA;
                    pr.type_code = itype;
                    pr.data_byte = b;
                    bytes_left   = bytes_left - 16'd1;
                    if (bytes_left == 16'd0) begin
                        pr.data_end = 1'b1;
                        finish_item();
                    end
                end
                PH_SOCK: begin
                    if (idx < 4'd2) begin
                        fam_hold = {fam_hold[7:0], b};
                    end else if (idx < 4'd4) begin
                        port_hold = {port_hold[7:0], b};
                    end else if (idx < 4'd8) begin
                        acc = {acc[23:0], b};
                    end
                    fidx = idx + 4'd1;
                    if (idx >= 4'd15) begin
                        pemit          = 1'b1;
                        pr.kind        = KIND_SOCK;
                        pr.type_code   = itype;
                        pr.sock_family = fam_hold;
                        pr.sock_port   = port_hold;
                        pr.sock_ipv4   = acc;
                        fam_hold       = '0;
                        port_hold      = '0;
                        acc            = '0;
                        finish_item();
                    end
                end
                default: begin
                    ph = PH_DONE;
                end
            endcase
            if (last && ph != PH_DONE) begin
                close_packet(ST_TRUNC);
            end
        end
        if (last) begin
            ph        = PH_COUNT;
            fidx      = '0;
            offs      = '0;
            acc       = '0;
            fam_hold  = '0;
            port_hold = '0;
        end
        if (pemit) begin
            predicted_results.push_back(pr);
        end
    endtask

    function automatic string fmt_result(input t_result r);
        return {$sformatf("kind=%0d type=%h conn=%h seq=%h data=%h/%b ",
                          r.kind, r.type_code, r.conn_id, r.seq_num, r.data_byte, r.data_end),
                $sformatf("sock=%h/%h/%h end=%b st=%0d off=%0d",
                          r.sock_family, r.sock_port, r.sock_ipv4, r.packet_end, r.status,
                          r.byte_offset)};
    endfunction

    // ------------------------------------------------------------------------
    // buffer building
    // ------------------------------------------------------------------------
    task automatic put_u16(input logic [15:0] v);
        frame_q.push_back(v[7:0]);
        frame_q.push_back(v[15:8]);
    endtask

    task automatic put_rand(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic send_frame(input int keep);
        for (int i = 0; i < keep; i++) begin
            byte_queue.push_back({frame_q[i], 1'(i == keep - 1)});
        end
        frame_q.delete();
    endtask

    task automatic build_frame();
        int          n_items;
        int          n_gen;
        int          sel;
        int          len;
        int          keep;
        logic [15:0] ty;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            n_items = 0;
        end else if (sel == 1) begin
            n_items = $urandom_range(5, 65535);
        end else begin
            n_items = $urandom_range(1, 4);
        end
        n_gen = (n_items > 4) ? $urandom_range(0, 6) : n_items;
        put_u16(16'(n_items));
        for (int k = 0; k < n_gen; k++) begin
            sel = $urandom_range(0, 19);
            case (sel) inside
                0, 1:         ty = TYPE_ADDR_NULL;
                2, 3:         ty = TYPE_ADDR_CONN;
                4, 5, 6:      ty = TYPE_ADDR_SEQ;
                7, 8, 9:      ty = TYPE_DATA_CONN;
                10, 11, 12:   ty = TYPE_DATA_UCON;
                13, 14:       ty = TYPE_SOCK_OT;
                15, 16:       ty = TYPE_SOCK_TO;
                17:           ty = 16'($urandom);
                default:      ty = TYPE_DATA_UCON;
            endcase
            put_u16(ty);
            case (ty) inside
                TYPE_ADDR_NULL, TYPE_ADDR_CONN, TYPE_ADDR_SEQ: begin
                    sel = $urandom_range(0, 9);
                    if (sel < 2) begin
                        len = $urandom_range(0, 3);
                    end else if (sel < 4) begin
                        len = 4;
                    end else if (sel < 8) begin
                        len = 8;
                    end else if (sel == 8) begin
                        len = $urandom_range(5, 12);
                    end else begin
                        len = $urandom_range(0, 65535);
                    end
                    put_u16(16'(len));
                    if (len >= 4) put_rand(4);
                    if (len == 8) put_rand(4);
                end
                TYPE_DATA_CONN, TYPE_DATA_UCON: begin
                    sel = $urandom_range(0, 19);
                    if (sel < 3) begin
                        len = 0;
                    end else if (sel == 19) begin
                        len = $urandom_range(200, 300);
                    end else if (sel > 12) begin
                        len = $urandom_range(4, 24);
                    end else begin
                        len = $urandom_range(1, 3);
                    end
                    put_u16(16'(len));
                    put_rand(len);
                end
                TYPE_SOCK_OT, TYPE_SOCK_TO: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 16;
                    put_u16(16'(len));
                    put_rand(16);
                end
                default: begin
                    put_u16(16'($urandom));
                    put_rand($urandom_range(0, 4));
                end
            endcase
        end
        // mostly exact buffers, some with trailing bytes, some cut short
        sel  = $urandom_range(0, 9);
        keep = frame_q.size();
        if (sel == 7) begin
            put_rand($urandom_range(1, 4));
            keep = frame_q.size();
        end else if (sel > 7) begin
            keep = $urandom_range(1, frame_q.size());
        end
        send_frame(keep);
    endtask

    // ------------------------------------------------------------------------
    // clock, reset, stimulus, end of run
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.byte_in     = '0;
        in_if.last_byte   = 1'b0;
        out_if.ready      = 1'b0;
        err_count         = 0;
        bytes_taken       = 0;

        // count of zero, then a trailing byte that must be ignored
        put_u16(16'h0000);
        frame_q.push_back(8'hFF);
        send_frame(frame_q.size());
        // short address item
        put_u16(16'h0001);
        put_u16(TYPE_ADDR_NULL);
        put_u16(16'h0000);
        send_frame(frame_q.size());
        // unknown type, all-ones fields
        put_u16(16'h0001);
        put_u16(16'hFFFF);
        put_u16(16'hFFFF);
        send_frame(frame_q.size());
        // one-byte buffer: truncated in the count
        frame_q.push_back(8'hFF);
        send_frame(1);
        // socket item with the wrong length
        put_u16(16'h0001);
        put_u16(TYPE_SOCK_TO);
        put_u16(16'h0000);
        send_frame(frame_q.size());

        while (byte_queue.size() < RANDOM_BYTES) build_frame();

        total_bytes = byte_queue.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_bytes) @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && predicted_results.size() == 0) begin
            $display("cpf_item_list_parser_unit test passed");
        end else begin
            $display("cpf_item_list_parser_unit test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // byte driver: bursts with random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            ph          = PH_COUNT;
            fidx        = '0;
            items_left  = '0;
            itype       = '0;
            ilen        = '0;
            bytes_left  = '0;
            acc         = '0;
            conn_hold   = '0;
            fam_hold    = '0;
            port_hold   = '0;
            offs        = '0;
            gap_left    = 0;
            burst_left  = $urandom_range(1, 24);
        end else begin
            if (in_if.valid && in_if.ready) begin
                parse_byte(in_if.byte_in, in_if.last_byte);
                bytes_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    next_byte = byte_queue.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.byte_in   <= next_byte.data;
                    in_if.last_byte <= next_byte.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_mode      = 0;
            rx_left      = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.kind, out_if.type_code, out_if.conn_id, out_if.seq_num,
                       out_if.data_byte, out_if.data_end, out_if.sock_family,
                       out_if.sock_port, out_if.sock_ipv4, out_if.packet_end,
                       out_if.status, out_if.byte_offset};
                if (predicted_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t: unexpected result %s", $realtime, fmt_result(got));
                    end
                end else begin
                    want = predicted_results.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp %s", fmt_result(want));
                            $display("  got %s", fmt_result(got));
                        end
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(32, 400);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (rx_left[1:0] == 2'd0);
                default: rdy = ($urandom_range(0, 9) != 0);
            endcase
            out_if.ready <= rdy && !hold_off;
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 1'b0;
            hold_left = 0;
            hold_cyc  = 0;
        end else begin
            hold_cyc++;
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    hold_off <= 1'b0;
                end
            end else if (hold_cyc % 20000 == 1500) begin
                hold_off  <= 1'b1;
                hold_left = HOLD_CYCLES;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_cycles = 0;
        end else begin
            run_cycles++;
            if (run_cycles >= CYCLE_LIMIT) begin
                $display("cpf_item_list_parser_unit test failed");
                $finish;
            end
        end
    end

endmodule
